>>> rtl/dnle_pkg.sv
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants of the DNS name label encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dnle_pkg;

    // Length field width; covers every label limit up to 63
    localparam int LEN_W = 6;

    localparam logic [7:0] SEP_CHAR = 8'h2E;

    // One finished label waiting in the buffer
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        logic             ovf;
        logic             ends;
    } label_desc_t;

    // One encoded output item
    typedef struct packed {
        logic [7:0] data;
        logic       is_len;
        logic       ends;
        logic       err;
    } out_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

>>> rtl/dns_name_label_encoder.sv
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Dotted host name in, one character per item; DNS label form out.
// ----------------------------------------------------------------------------
// The input side takes one character per cycle and stores label bytes in one
// half of a two-label buffer RAM (2*MAX_LABEL bytes); a dot or the last
// character closes the label and hands it to the output side through a
// two-entry descriptor queue. The output side sends one item per cycle while
// m_tready is high: the length byte, then the label bytes read from the RAM.
// A label of n stored bytes gives n+1 output items. Input stalls only while
// both buffer halves hold labels whose bytes are not yet all read out, so
// sustained rate with m_tready high is one item per cycle, bound by the
// single output port. With the output side idle, the length byte goes from
// the descriptor queue through the read stage into the output queue and onto m_tvalid.
`default_nettype none

module dns_name_label_encoder #(
    parameter int MAX_LABEL = 63
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
    input  wire logic        s_tlast,   // last_char
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [8] label_too_long, rest 0
    output logic             m_tlast,   // name_end
    output logic [0:0]       m_tuser    // [0] is_length
);

    import dnle_pkg::*;

    localparam int AW = $clog2(2*MAX_LABEL);

    q_status_t   q_status;
    logic        push;
    label_desc_t push_desc;
    logic        pop;
    label_desc_t head;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    dnle_front #(.MAX_LABEL(MAX_LABEL)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_status  (q_status),
        .push      (push),
        .push_desc (push_desc),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    dnle_ram #(.WIDTH(8), .DEPTH(2*MAX_LABEL), .AW(AW)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dnle_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    dnle_back #(.MAX_LABEL(MAX_LABEL)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .head      (head),
        .pop       (pop),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

>>> rtl/dnle_ram.sv
// ----------------------------------------------------------------------------
// dnle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 126,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/dnle_front.sv
// ----------------------------------------------------------------------------
// dnle_front
// Accepts characters, stores label bytes in the current buffer half and
// posts a label descriptor when a dot or the last character ends a label.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_front #(
    parameter int MAX_LABEL = 63
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,
    input  wire logic                  s_tlast,
    input  wire dnle_pkg::q_status_t   q_status,
    output logic                       push,
    output dnle_pkg::label_desc_t      push_desc,
    output logic                       ram_we,
    output logic [$clog2(2*MAX_LABEL)-1:0] ram_waddr,
    output logic [7:0]                 ram_wdata
);

    import dnle_pkg::*;

    localparam int AW = $clog2(2*MAX_LABEL);

    logic             bank_reg, bank_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;

    logic             accept;
    logic             is_sep;
    logic             room;
    logic [LEN_W-1:0] cnt_eff;
    logic             ovf_eff;

    // both buffer halves busy means the queue is full
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign is_sep   = (s_tdata == SEP_CHAR);
    assign room     = (cnt_reg < LEN_W'(MAX_LABEL));

    assign ram_wdata = s_tdata;
    assign ram_waddr = AW'(cnt_reg) + (bank_reg ? AW'(MAX_LABEL) : AW'(0));

    always_comb begin
        ram_we    = accept && !is_sep && room;
        cnt_eff   = (!is_sep && room) ? cnt_reg + LEN_W'(1) : cnt_reg;
        ovf_eff   = ovf_reg | (!is_sep && !room);
        push      = accept && (is_sep || s_tlast);
        push_desc = '{bank: bank_reg, len: cnt_eff, ovf: ovf_eff, ends: s_tlast};
        bank_next = bank_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        if (push) begin
            bank_next = !bank_reg;
            cnt_next  = '0;
            ovf_next  = 1'b0;
        end else if (accept) begin
            cnt_next = cnt_eff;
            ovf_next = ovf_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg <= 1'b0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            bank_reg <= bank_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dnle_queue.sv
// ----------------------------------------------------------------------------
// dnle_queue
// Two-entry queue of label descriptors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire dnle_pkg::label_desc_t push_desc,
    input  wire logic                  pop,
    output dnle_pkg::label_desc_t      head,
    output dnle_pkg::q_status_t        q_status
);

    import dnle_pkg::*;

    label_desc_t entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;

    assign head           = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == 2'd2);
    assign q_status.empty = (count_reg == 2'd0);

    always_comb begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dnle_back.sv
// ----------------------------------------------------------------------------
// dnle_back
// Walks the head label: length byte first, then its bytes from the buffer,
// through a read stage and a two-entry output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_back #(
    parameter int MAX_LABEL = 63
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dnle_pkg::q_status_t   q_status,
    input  wire dnle_pkg::label_desc_t head,
    output logic                       pop,
    output logic [$clog2(2*MAX_LABEL)-1:0] ram_raddr,
    input  wire logic [7:0]            ram_rdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata,
    output logic                       m_tlast,
    output logic [0:0]                 m_tuser
);

    import dnle_pkg::*;

    localparam int AW = $clog2(2*MAX_LABEL);

    typedef struct packed {
        logic      from_ram;
        out_item_t item;
    } token_t;

    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             s1_valid_reg;
    token_t           s1_tok_reg;
    token_t           tok;

    out_item_t        obuf_reg [2];
    logic             owr_ptr_reg, ord_ptr_reg;
    logic [1:0]       ocount_reg, ocount_next;

    logic [1:0]       occ;
    logic             out_pop;
    logic             can_issue;
    logic             issue;
    logic             at_end;
    logic [LEN_W-1:0] rd_idx;
    out_item_t        s1_item;
    out_item_t        out_head;

    assign out_pop   = m_tvalid && m_tready;
    // items held or in flight must fit in the output queue
    assign occ       = ocount_reg + {1'b0, s1_valid_reg};
    assign can_issue = (occ < 2'd2) || ((occ == 2'd2) && out_pop);
    assign issue     = !q_status.empty && can_issue;
    assign at_end    = (idx_reg == head.len);
    assign pop       = issue && at_end;

    assign rd_idx    = idx_reg - LEN_W'(1);
    assign ram_raddr = AW'(rd_idx) + (head.bank ? AW'(MAX_LABEL) : AW'(0));

    always_comb begin
        tok.from_ram    = (idx_reg != '0);
        tok.item.data   = 8'(head.len);
        tok.item.is_len = (idx_reg == '0);
        tok.item.ends   = head.ends && at_end;
        tok.item.err    = head.ovf;
        idx_next        = idx_reg;
        if (issue) begin
            idx_next = at_end ? '0 : idx_reg + LEN_W'(1);
        end
    end

    always_comb begin
        s1_item = s1_tok_reg.item;
        if (s1_tok_reg.from_ram) begin
            s1_item.data = ram_rdata;
        end
        ocount_next = ocount_reg + {1'b0, s1_valid_reg} - {1'b0, out_pop};
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_tok_reg <= tok;
        end
        if (s1_valid_reg) begin
            obuf_reg[owr_ptr_reg] <= s1_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            owr_ptr_reg  <= 1'b0;
            ord_ptr_reg  <= 1'b0;
            ocount_reg   <= '0;
        end else begin
            idx_reg      <= idx_next;
            s1_valid_reg <= issue;
            if (s1_valid_reg) begin
                owr_ptr_reg <= !owr_ptr_reg;
            end
            if (out_pop) begin
                ord_ptr_reg <= !ord_ptr_reg;
            end
            ocount_reg <= ocount_next;
        end
    end

    assign out_head   = obuf_reg[ord_ptr_reg];
    assign m_tvalid   = (ocount_reg != 2'd0);
    assign m_tdata    = {7'b0, out_head.err, out_head.data};
    assign m_tlast    = out_head.ends;
    assign m_tuser[0] = out_head.is_len;

endmodule

`default_nettype wire

>>> rtl/dnle_checker.sv
// ----------------------------------------------------------------------------
// dnle_checker
// Port-level checks of the DNS name label encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_checker #(
    parameter int MAX_LABEL = 63
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [0:0]  m_tuser
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output item valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled output item changed");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[7:0] <= 8'(MAX_LABEL))
        else $error("length byte above label limit");

    a_trunc_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && m_tdata[8] |-> m_tdata[7:0] == 8'(MAX_LABEL))
        else $error("truncated label without saturated length");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:9] == 7'd0)
        else $error("output padding bits not zero");

endmodule

bind dns_name_label_encoder dnle_checker #(.MAX_LABEL(MAX_LABEL)) u_dnle_checker (.*);

`default_nettype wire
